// ===== rtl/core/clr_pkg.sv =====
// Shared types and constants for the clipped line rasterizer.
// No dependencies; imported by every module of the block.
package clr_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int DIM_BITS           = 16;
    localparam int ADDR_BITS          = 32;
    localparam int COLOR_BITS         = 24;

    localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RESET  = DIM_BITS'(600);
    localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RESET = DIM_BITS'(600);

    // op codes carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // control bits of the pixel stage handed to the address stage
    typedef struct packed {
        logic valid;
        logic in_frame;
        logic last;
    } pix_ctl_t;

endpackage

// ===== rtl/core/clr_walker.sv =====
// Bresenham walker: line setup on load, one step per emitted pixel, clip test.
// Depends on clr_pkg.
module clr_walker
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic                         step,
    input  logic                         advance,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic [COLOR_BITS-1:0]        line_color,
    input  logic [DIM_BITS-1:0]          image_width,
    input  logic [DIM_BITS-1:0]          image_height,
    output logic signed [COORD_BITS-1:0] pix_x,
    output logic signed [COORD_BITS-1:0] pix_y,
    output logic [COLOR_BITS-1:0]        pix_color,
    output pix_ctl_t                     pix_ctl
);

    localparam int D = COORD_BITS + 1;   // delta width
    localparam int E = COORD_BITS + 3;   // error term width
    localparam int W = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] goal_x_reg, goal_x_next;
    logic signed [COORD_BITS-1:0] goal_y_reg, goal_y_next;
    logic signed [D-1:0]          delta_x_reg, delta_x_next;
    logic signed [D-1:0]          neg_delta_y_reg, neg_delta_y_next;
    logic                         step_x_neg_reg, step_x_neg_next;
    logic                         step_y_neg_reg, step_y_neg_next;
    logic signed [E-1:0]          error_reg, error_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;
    logic                         active_reg, active_next;

    logic signed [COORD_BITS-1:0] pix_x_reg, pix_y_reg;
    logic [COLOR_BITS-1:0]        pix_color_reg;
    pix_ctl_t                     pix_ctl_reg, pix_ctl_next;

    logic signed [D-1:0] diff_x, diff_y, abs_x, abs_y;
    logic signed [E:0]   e2;
    logic signed [E:0]   ndy_e2, dx_e2;
    logic                move_x, move_y, at_end, emit;
    logic [W-1:0]        xw, yw, ww, hw;
    logic                in_frame;

    // setup
    always_comb begin
        diff_x = D'(end_x) - D'(start_x);
        diff_y = D'(end_y) - D'(start_y);
        abs_x  = diff_x[D-1] ? -diff_x : diff_x;
        abs_y  = diff_y[D-1] ? -diff_y : diff_y;
    end

    // one Bresenham step
    always_comb begin
        e2     = {error_reg, 1'b0};
        ndy_e2 = (E+1)'(neg_delta_y_reg);
        dx_e2  = (E+1)'(delta_x_reg);
        move_x = (e2 >= ndy_e2);
        move_y = (e2 <= dx_e2);
        at_end = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);
        emit   = step && active_reg;
    end

    // clip test against the frame
    always_comb begin
        xw       = {{(W-COORD_BITS){cur_x_reg[COORD_BITS-1]}}, cur_x_reg};
        yw       = {{(W-COORD_BITS){cur_y_reg[COORD_BITS-1]}}, cur_y_reg};
        ww       = {{(W-DIM_BITS){1'b0}}, image_width};
        hw       = {{(W-DIM_BITS){1'b0}}, image_height};
        in_frame = !xw[W-1] && !yw[W-1] && (xw < ww) && (yw < hw);
    end

    always_comb begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        goal_x_next      = goal_x_reg;
        goal_y_next      = goal_y_reg;
        delta_x_next     = delta_x_reg;
        neg_delta_y_next = neg_delta_y_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        error_next       = error_reg;
        color_next       = color_reg;
        active_next      = active_reg;
        if (load) begin
            cur_x_next       = start_x;
            cur_y_next       = start_y;
            goal_x_next      = end_x;
            goal_y_next      = end_y;
            delta_x_next     = abs_x;
            neg_delta_y_next = -abs_y;
            step_x_neg_next  = !(start_x < end_x);
            step_y_neg_next  = !(start_y < end_y);
            error_next       = E'(abs_x) - E'(abs_y);
            color_next       = line_color;
            active_next      = 1'b1;
        end else if (emit) begin
            if (at_end) begin
                active_next = 1'b0;
            end else begin
                error_next = error_reg
                           + (move_x ? E'(neg_delta_y_reg) : E'(0))
                           + (move_y ? E'(delta_x_reg) : E'(0));
                if (move_x) begin
                    cur_x_next = step_x_neg_reg ? cur_x_reg - COORD_BITS'(1)
                                                : cur_x_reg + COORD_BITS'(1);
                end
                if (move_y) begin
                    cur_y_next = step_y_neg_reg ? cur_y_reg - COORD_BITS'(1)
                                                : cur_y_reg + COORD_BITS'(1);
                end
            end
        end
    end

    always_comb begin
        pix_ctl_next = pix_ctl_reg;
        if (emit) begin
            pix_ctl_next.valid    = 1'b1;
            pix_ctl_next.in_frame = in_frame;
            pix_ctl_next.last     = at_end;
        end else if (advance) begin
            pix_ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            delta_x_reg     <= '0;
            neg_delta_y_reg <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            error_reg       <= '0;
            color_reg       <= '0;
            active_reg      <= 1'b0;
            pix_ctl_reg     <= '0;
        end else begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            goal_x_reg      <= goal_x_next;
            goal_y_reg      <= goal_y_next;
            delta_x_reg     <= delta_x_next;
            neg_delta_y_reg <= neg_delta_y_next;
            step_x_neg_reg  <= step_x_neg_next;
            step_y_neg_reg  <= step_y_neg_next;
            error_reg       <= error_next;
            color_reg       <= color_next;
            active_reg      <= active_next;
            pix_ctl_reg     <= pix_ctl_next;
        end
    end

    // pixel payload, no reset needed
    always_ff @(posedge aclk) begin
        if (emit) begin
            pix_x_reg     <= cur_x_reg;
            pix_y_reg     <= cur_y_reg;
            pix_color_reg <= color_reg;
        end
    end

    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign pix_color = pix_color_reg;
    assign pix_ctl   = pix_ctl_reg;

endmodule

// ===== rtl/core/clr_addr.sv =====
// Address stage: row-major address width*y+x and the output register.
// Depends on clr_pkg.
module clr_addr
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic signed [COORD_BITS-1:0] pix_x,
    input  logic signed [COORD_BITS-1:0] pix_y,
    input  logic [COLOR_BITS-1:0]        pix_color,
    input  pix_ctl_t                     pix_ctl,
    input  logic [DIM_BITS-1:0]          image_width,
    output logic                         out_valid,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic [ADDR_BITS-1:0]         out_address,
    output logic [COLOR_BITS-1:0]        out_color,
    output logic                         out_write_enable,
    output logic                         out_last
);

    localparam int W = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

    logic                         valid_reg, valid_next;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [ADDR_BITS-1:0]         address_reg, address_next;
    logic [COLOR_BITS-1:0]        color_reg;
    logic                         we_reg, last_reg;

    logic [W-1:0]         xw, yw;
    logic [ADDR_BITS-1:0] product;

    // an inside pixel has 0 <= x,y < 2^16, so the low 16 bits carry it whole
    always_comb begin
        xw      = {{(W-COORD_BITS){pix_x[COORD_BITS-1]}}, pix_x};
        yw      = {{(W-COORD_BITS){pix_y[COORD_BITS-1]}}, pix_y};
        product = ADDR_BITS'(image_width) * ADDR_BITS'(yw[DIM_BITS-1:0]);
        address_next = pix_ctl.in_frame ? product + ADDR_BITS'(xw[DIM_BITS-1:0])
                                        : '0;
        valid_next   = advance ? pix_ctl.valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && pix_ctl.valid) begin
            x_reg       <= pix_x;
            y_reg       <= pix_y;
            address_reg <= address_next;
            color_reg   <= pix_color;
            we_reg      <= pix_ctl.in_frame;
            last_reg    <= pix_ctl.last;
        end
    end

    assign out_valid        = valid_reg;
    assign out_x            = x_reg;
    assign out_y            = y_reg;
    assign out_address      = address_reg;
    assign out_color        = color_reg;
    assign out_write_enable = we_reg;
    assign out_last         = last_reg;

endmodule

// ===== rtl/core/clipped_line_rasterizer.sv =====
// Top level of the clipped line rasterizer: stream ports, frame size registers.
// Depends on clr_pkg, clr_walker and clr_addr.
//
// All-octant Bresenham line walker with clipping to a width x height frame.
// A load word (tuser = 0) latches both endpoints and the color and emits
// nothing; each step word (tuser = 1) emits the current pixel and moves one
// step toward the end point. Pixels outside the frame still come out, with
// write enable low and address zero; tlast marks the end point, after which
// step words are dropped until the next load. A load replaces a line in
// progress. Throughput is one word per clock while s_tready is high: the
// walker state advances in the cycle a word is taken, and a pixel passes
// through the walker's pixel register, then the 16x16 address multiplier
// into the output register that drives m_tdata. s_tready drops only while
// both stages hold a pixel the sink has not taken. Frame size registers must
// be written while no line is in flight; writes to other indexes are ignored.
module clipped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int  COORD_BITS  = COORD_BITS_DEFAULT,
    localparam int S_RAW_BITS  = 4 * COORD_BITS + COLOR_BITS,
    localparam int S_DATA_BITS = ((S_RAW_BITS + 7) / 8) * 8,
    localparam int M_RAW_BITS  = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS + 1,
    localparam int M_DATA_BITS = ((M_RAW_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [DIM_BITS-1:0]    cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // start_x, start_y, end_x, end_y, line_color, zero fill
    input  logic [S_DATA_BITS-1:0] s_tdata,
    // op
    input  logic                   s_tuser,
    // pixel stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pixel_x, pixel_y, pixel_address, pixel_color, write_enable, zero fill
    output logic [M_DATA_BITS-1:0] m_tdata,
    output logic                   m_tlast
);

    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;

    logic s_accept, load, step, advance;

    logic signed [COORD_BITS-1:0] in_start_x, in_start_y, in_end_x, in_end_y;
    logic [COLOR_BITS-1:0]        in_color;

    logic signed [COORD_BITS-1:0] pix_x, pix_y;
    logic [COLOR_BITS-1:0]        pix_color;
    pix_ctl_t                     pix_ctl;

    logic signed [COORD_BITS-1:0] out_x, out_y;
    logic [ADDR_BITS-1:0]         out_address;
    logic [COLOR_BITS-1:0]        out_color;
    logic                         out_write_enable;

    // frame size registers
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_next  = cfg_wdata;
                REG_IMAGE_HEIGHT: height_next = cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // input word unpacking
    assign in_start_x = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign in_start_y = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign in_end_x   = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign in_end_y   = s_tdata[3*COORD_BITS +: COORD_BITS];
    assign in_color   = s_tdata[4*COORD_BITS +: COLOR_BITS];

    // output register frees up when empty or being taken; the pixel stage
    // can then always move forward, so the input side only waits on it
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !pix_ctl.valid || advance;
    assign s_accept = s_tvalid && s_tready;
    assign load     = s_accept && (s_tuser == OP_LOAD);
    assign step     = s_accept && (s_tuser == OP_STEP);

    clr_walker #(
        .COORD_BITS(COORD_BITS)
    ) u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .step        (step),
        .advance     (advance),
        .start_x     (in_start_x),
        .start_y     (in_start_y),
        .end_x       (in_end_x),
        .end_y       (in_end_y),
        .line_color  (in_color),
        .image_width (width_reg),
        .image_height(height_reg),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .pix_color   (pix_color),
        .pix_ctl     (pix_ctl)
    );

    clr_addr #(
        .COORD_BITS(COORD_BITS)
    ) u_addr (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .pix_x           (pix_x),
        .pix_y           (pix_y),
        .pix_color       (pix_color),
        .pix_ctl         (pix_ctl),
        .image_width     (width_reg),
        .out_valid       (m_tvalid),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_address     (out_address),
        .out_color       (out_color),
        .out_write_enable(out_write_enable),
        .out_last        (m_tlast)
    );

    assign m_tdata = M_DATA_BITS'({out_write_enable, out_color, out_address, out_y, out_x});

    // a clipped pixel never carries an address
    a_clip_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_write_enable |-> out_address == '0)
        else $error("clipped pixel with nonzero address");

    // input only stalls when both pixel stages are full and the sink waits
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> pix_ctl.valid && m_tvalid && !m_tready)
        else $error("input stalled without a full pipeline");

    // a written pixel has nonnegative x and y
    a_we_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_write_enable |->
            !out_x[COORD_BITS-1] && !out_y[COORD_BITS-1])
        else $error("write enable on negative coordinate");

    // a pixel waiting in the pixel stage moves to the output when it frees up
    a_pixel_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_ctl.valid && advance |=> m_tvalid)
        else $error("pixel dropped between stages");

endmodule
